// ===== hw/rtl/sfd_pkg.sv =====
// Shared types and constants of the sync frame decoder.
package sfd_pkg;

    localparam int WINDOW_LEN = 7;
    localparam int RATE_SLOTS = 2;

    // Magic word 0x5643414e, first received byte in element 0.
    localparam logic [3:0][7:0] MAGIC = {8'h56, 8'h43, 8'h41, 8'h4e};
    localparam logic [7:0] VERSION_OK = 8'd1;

    // Frame offsets counted from the magic.
    localparam logic [7:0] OFS_SEQ        = 8'd5;
    localparam logic [7:0] OFS_COUNT      = 8'd6;
    localparam logic [7:0] OFS_MASK       = 8'd7;
    localparam logic [7:0] OFS_RATE       = 8'd16;
    localparam logic [7:0] OFS_ENTRY      = 8'd24;
    localparam int         ENTRY_BYTES    = 16;

    typedef logic [WINDOW_LEN-1:0][7:0] window_t;

    typedef enum logic [2:0] {
        KIND_SEQ      = 3'd0,
        KIND_RATE     = 3'd1,
        KIND_TX       = 3'd2,
        KIND_BAD_LEN  = 3'd3,
        KIND_BAD_CHAN = 3'd4
    } kind_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] shift;
    } magic_res_t;

endpackage

// ===== hw/rtl/sfd_magic_search.sv =====
// Header magic search over the byte shifts with the version check.
module sfd_magic_search
    import sfd_pkg::*;
#(
    parameter int MAX_SHIFT = 3
)
(
    input  window_t     window,
    input  logic [7:0]  pos,
    input  logic [7:0]  rx_byte,
    output magic_res_t  result
);

    function automatic logic magic_at(input window_t w, input int s);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (w[s + k] != MAGIC[k]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        logic earlier;
        earlier = 1'b0;
        result  = '0;
        for (int s = 0; s < 4; s++) begin
            // The version byte of shift s arrives at position four plus s; an
            // earlier shift that already held the magic settles the frame.
            if (s <= MAX_SHIFT && pos == 8'(4 + s) && !earlier
                && magic_at(window, s) && rx_byte == VERSION_OK) begin
                result.hit   = 1'b1;
                result.shift = 2'(s);
            end
            if (s <= MAX_SHIFT) begin
                earlier = earlier | magic_at(window, s);
            end
        end
    end

endmodule

// ===== hw/rtl/sync_frame_decoder_unit.sv =====
// Top level of the sync frame decoder: input register, decode and result register.
//
//  Channel | Handshake         | Payload
//  --------+-------------------+---------------------------------------------------
//  in      | in_valid/in_stall | rx_byte, frame_start
//  out     | out_valid/out_stall | kind, seq_number, channel, bitrate, entry_index,
//          |                   | can_id, data_length, frame_flags, payload
//
// Each byte passes through the input register and then the result register on its
// way from input beat to result beat. A new byte is accepted every cycle while in_stall is low.
// The decode stage advances whenever the result register is empty or being
// drained, so in_stall only rises while out_stall holds a waiting result.
// Reset clears the frame state and header window; the field buffer needs none.
module sync_frame_decoder_unit
    import sfd_pkg::*;
#(
    parameter int FRAME_BYTES = 192,
    parameter int MAX_ENTRIES = 4,
    parameter int CHANNELS    = 2,
    parameter int MAX_SHIFT   = 3
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  seq_number,
    output logic [7:0]  channel,
    output logic [31:0] bitrate,
    output logic [1:0]  entry_index,
    output logic [31:0] can_id,
    output logic [7:0]  data_length,
    output logic [7:0]  frame_flags,
    output logic [63:0] payload
);

    // Region limits, worked out at elaboration.
    localparam logic [8:0] FRAME_LIMIT = 9'(FRAME_BYTES);
    localparam logic [8:0] ENTRY_END   = 9'(24 + ENTRY_BYTES * MAX_ENTRIES);
    localparam logic [8:0] CHAN_LIMIT  = 9'(CHANNELS);
    localparam logic [8:0] RATE_LIMIT  = 9'(RATE_SLOTS);
    localparam logic [2:0] ENTRY_CAP   = 3'(MAX_ENTRIES);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       frame_start_reg;

    // Frame state.
    logic [7:0] byte_position_reg, byte_position_next;
    window_t    window_reg, window_next;
    logic [1:0] shift_reg, shift_next;
    logic       accepted_reg, accepted_next;
    logic [2:0] entry_count_reg, entry_count_next;
    logic [7:0] rate_mask_reg, rate_mask_next;
    logic [7:0] field_buf_reg [ENTRY_BYTES];

    // Result register.
    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  channel_reg, channel_next;
    logic [31:0] bitrate_reg, bitrate_next;
    logic [1:0]  index_reg, index_next;
    logic [31:0] can_id_reg, can_id_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  flags_reg, flags_next;
    logic [63:0] payload_reg, payload_next;

    logic       out_free;
    logic       advance;
    logic       emit;
    logic       buf_write;
    logic [3:0] buf_index;
    logic [7:0] pos;
    logic [7:0] f;
    logic [7:0] rate_ofs;
    logic [7:0] entry_ofs;
    magic_res_t magic;

    // The decode stage runs when the result register can take its answer.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    assign pos       = frame_start_reg ? 8'd0 : byte_position_reg;
    assign f         = pos - {6'd0, shift_reg};
    assign rate_ofs  = f - OFS_RATE;
    assign entry_ofs = f - OFS_ENTRY;

    sfd_magic_search #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_magic (
        .window  (window_reg),
        .pos     (pos),
        .rx_byte (rx_byte_reg),
        .result  (magic)
    );

    always_comb
    begin
        byte_position_next = (pos == 8'hff) ? pos : pos + 8'd1;
        window_next        = window_reg;
        shift_next         = frame_start_reg ? 2'd0 : shift_reg;
        accepted_next      = frame_start_reg ? 1'b0 : accepted_reg;
        entry_count_next   = frame_start_reg ? 3'd0 : entry_count_reg;
        rate_mask_next     = frame_start_reg ? 8'd0 : rate_mask_reg;
        buf_write          = 1'b0;
        buf_index          = '0;
        emit               = 1'b0;
        kind_next          = KIND_SEQ;
        seq_next           = '0;
        channel_next       = '0;
        bitrate_next       = '0;
        index_next         = '0;
        can_id_next        = '0;
        length_next        = '0;
        flags_next         = '0;
        payload_next       = '0;

        // Bytes past the end of the frame are ignored until the next start mark.
        if ({1'b0, pos} < FRAME_LIMIT) begin
            if (pos < 8'(WINDOW_LEN)) begin
                window_next[pos[2:0]] = rx_byte_reg;
            end

            if (!accepted_next) begin
                if (magic.hit) begin
                    accepted_next = 1'b1;
                    shift_next    = magic.shift;
                end
            end else if (f == OFS_SEQ) begin
                emit     = 1'b1;
                seq_next = rx_byte_reg;
            end else if (f == OFS_COUNT) begin
                entry_count_next = ({1'b0, rx_byte_reg} < 9'(MAX_ENTRIES))
                                   ? rx_byte_reg[2:0] : ENTRY_CAP;
            end else if (f == OFS_MASK) begin
                rate_mask_next = rx_byte_reg;
            end else if (f >= OFS_RATE && f < OFS_ENTRY) begin
                // Two little-endian bitrate words; report on the top byte.
                buf_write = 1'b1;
                buf_index = {2'd0, rate_ofs[1:0]};
                if (rate_ofs[1:0] == 2'd3
                    && {8'd0, rate_ofs[2]} < CHAN_LIMIT
                    && {8'd0, rate_ofs[2]} < RATE_LIMIT
                    && rate_mask_reg[rate_ofs[2]]) begin
                    bitrate_next = {rx_byte_reg, field_buf_reg[2], field_buf_reg[1],
                                    field_buf_reg[0]};
                    if (bitrate_next != 32'd0) begin
                        emit         = 1'b1;
                        kind_next    = KIND_RATE;
                        channel_next = {7'd0, rate_ofs[2]};
                    end else begin
                        bitrate_next = '0;
                    end
                end
            end else if ({1'b0, f} >= {1'b0, OFS_ENTRY} && {1'b0, f} < ENTRY_END) begin
                // CAN entries: collect sixteen bytes, judge on the last one.
                buf_write = 1'b1;
                buf_index = entry_ofs[3:0];
                if (entry_ofs[3:0] == 4'd15 && {1'b0, entry_ofs[5:4]} < entry_count_reg) begin
                    emit         = 1'b1;
                    channel_next = field_buf_reg[6];
                    index_next   = entry_ofs[5:4];
                    can_id_next  = {field_buf_reg[3], field_buf_reg[2], field_buf_reg[1],
                                    field_buf_reg[0]};
                    length_next  = field_buf_reg[4];
                    flags_next   = field_buf_reg[5];
                    // Length is checked before the channel.
                    if (field_buf_reg[4] > 8'd8) begin
                        kind_next = KIND_BAD_LEN;
                    end else if ({1'b0, field_buf_reg[6]} >= CHAN_LIMIT) begin
                        kind_next = KIND_BAD_CHAN;
                    end else begin
                        kind_next    = KIND_TX;
                        payload_next = {rx_byte_reg, field_buf_reg[14], field_buf_reg[13],
                                        field_buf_reg[12], field_buf_reg[11],
                                        field_buf_reg[10], field_buf_reg[9],
                                        field_buf_reg[8]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            rx_byte_reg     <= rx_byte;
            frame_start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_position_reg <= '0;
            window_reg        <= '0;
            shift_reg         <= '0;
            accepted_reg      <= 1'b0;
            entry_count_reg   <= '0;
            rate_mask_reg     <= '0;
        end else if (advance) begin
            byte_position_reg <= byte_position_next;
            window_reg        <= window_next;
            shift_reg         <= shift_next;
            accepted_reg      <= accepted_next;
            entry_count_reg   <= entry_count_next;
            rate_mask_reg     <= rate_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && buf_write) begin
            field_buf_reg[buf_index] <= rx_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit) begin
            kind_reg    <= kind_next;
            seq_reg     <= seq_next;
            channel_reg <= channel_next;
            bitrate_reg <= bitrate_next;
            index_reg   <= index_next;
            can_id_reg  <= can_id_next;
            length_reg  <= length_next;
            flags_reg   <= flags_next;
            payload_reg <= payload_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign seq_number  = seq_reg;
    assign channel     = channel_reg;
    assign bitrate     = bitrate_reg;
    assign entry_index = index_reg;
    assign can_id      = can_id_reg;
    assign data_length = length_reg;
    assign frame_flags = flags_reg;
    assign payload     = payload_reg;

endmodule

// ===== dv/sfd_tb_pkg.sv =====
// Scoreboard class and byte-level decode prediction for the sync frame decoder testbench.
`timescale 1ns / 1ps

package sfd_tb_pkg;

    import sfd_pkg::*;

    // Build settings of the unit under test, passed down to its parameters.
    localparam int FRAME_LEN     = 192;
    localparam int ENTRY_SLOTS   = 4;
    localparam int CHANNEL_COUNT = 2;
    localparam int SHIFT_LIMIT   = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  seq_number;
        logic [7:0]  channel;
        logic [31:0] bitrate;
        logic [1:0]  entry_index;
        logic [31:0] can_id;
        logic [7:0]  data_length;
        logic [7:0]  frame_flags;
        logic [63:0] payload;
    } decode_result_t;

    class frame_decode_scoreboard;

        decode_result_t pending_results[$];
        int             errors;
        int             results_predicted;

        int unsigned    position;
        logic [7:0]     window [WINDOW_LEN];
        int unsigned    shift;
        bit             accepted;
        int unsigned    entry_limit;
        logic [7:0]     rate_mask;
        logic [7:0]     field_bytes [16];

        function new();
            position          = 0;
            shift             = 0;
            accepted          = 1'b0;
            entry_limit       = 0;
            rate_mask         = 8'h00;
            errors            = 0;
            results_predicted = 0;
            foreach (window[i]) window[i] = 8'h00;
            foreach (field_bytes[i]) field_bytes[i] = 8'h00;
        endfunction

        function bit magic_at(int unsigned s);
            for (int unsigned k = 0; k < 4; k++) begin
                if (s + k >= WINDOW_LEN || window[s + k] != MAGIC[k]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic [31:0] word_at(int unsigned base);
            return {field_bytes[base + 3], field_bytes[base + 2],
                    field_bytes[base + 1], field_bytes[base]};
        endfunction

        function void push_result(decode_result_t r);
            pending_results.push_back(r);
            results_predicted++;
        endfunction

        // Advances the decode state by one accepted input beat.
        function void note_byte(logic [7:0] b, logic st);
            int unsigned    p;
            int unsigned    f;
            int unsigned    ch;
            int unsigned    k;
            int unsigned    idx;
            decode_result_t r;
            if (st) begin
                p           = 0;
                accepted    = 1'b0;
                shift       = 0;
                entry_limit = 0;
                rate_mask   = 8'h00;
            end else begin
                p = position;
            end
            position = (p < 255) ? p + 1 : 255;
            if (p >= FRAME_LEN) return;
            if (p < WINDOW_LEN) window[p] = b;

            if (!accepted) begin
                // The header is judged on the version byte of each candidate shift.
                if (p >= 4 && p <= 4 + SHIFT_LIMIT) begin
                    for (int unsigned j = 0; j < p - 4; j++) begin
                        if (magic_at(j)) return;
                    end
                    if (magic_at(p - 4) && b == VERSION_OK) begin
                        accepted = 1'b1;
                        shift    = p - 4;
                    end
                end
                return;
            end

            f = p - shift;
            r = '0;
            if (f == OFS_SEQ) begin
                r.kind       = KIND_SEQ;
                r.seq_number = b;
                push_result(r);
            end else if (f == OFS_COUNT) begin
                entry_limit = (b < ENTRY_SLOTS) ? b : ENTRY_SLOTS;
            end else if (f == OFS_MASK) begin
                rate_mask = b;
            end else if (f >= OFS_RATE && f < OFS_ENTRY) begin
                ch = (f - OFS_RATE) >> 2;
                k  = (f - OFS_RATE) & 3;
                field_bytes[k] = b;
                if (k == 3 && ch < CHANNEL_COUNT && ch < RATE_SLOTS && rate_mask[ch]
                    && word_at(0) != 32'h0) begin
                    r.kind    = KIND_RATE;
                    r.channel = 8'(ch);
                    r.bitrate = word_at(0);
                    push_result(r);
                end
            end else if (f >= OFS_ENTRY && f < OFS_ENTRY + ENTRY_BYTES * ENTRY_SLOTS) begin
                idx = (f - OFS_ENTRY) / ENTRY_BYTES;
                k   = (f - OFS_ENTRY) % ENTRY_BYTES;
                field_bytes[k] = b;
                if (k == ENTRY_BYTES - 1 && idx < entry_limit) begin
                    r.channel     = field_bytes[6];
                    r.entry_index = 2'(idx);
                    r.can_id      = word_at(0);
                    r.data_length = field_bytes[4];
                    r.frame_flags = field_bytes[5];
                    // Length is checked ahead of the channel.
                    if (field_bytes[4] > 8) begin
                        r.kind = KIND_BAD_LEN;
                    end else if (field_bytes[6] >= CHANNEL_COUNT) begin
                        r.kind = KIND_BAD_CHAN;
                    end else begin
                        r.kind = KIND_TX;
                        for (int j = 0; j < 8; j++) r.payload[8 * j +: 8] = field_bytes[8 + j];
                    end
                    push_result(r);
                end
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(decode_result_t got);
            decode_result_t want;
            if (pending_results.size() == 0) begin
                $error("result beat of kind %0d with no result pending", got.kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("seq_number", want.seq_number, got.seq_number);
            compare_field("channel", want.channel, got.channel);
            compare_field("bitrate", want.bitrate, got.bitrate);
            compare_field("entry_index", want.entry_index, got.entry_index);
            compare_field("can_id", want.can_id, got.can_id);
            compare_field("data_length", want.data_length, got.data_length);
            compare_field("frame_flags", want.frame_flags, got.frame_flags);
            compare_field("payload", want.payload, got.payload);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

    endclass

endpackage

// ===== dv/tb_sync_frame_decoder_unit.sv =====
// Testbench top for the sync frame decoder: frame stimulus, result checking and watchdog.
`timescale 1ns / 1ps

module tb_sync_frame_decoder_unit;

    import sfd_pkg::*;
    import sfd_tb_pkg::*;

    // Roughly how many counted input beats the random part sends.
    localparam int RANDOM_ITEMS   = 250;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES    = 150;
    // Cycles without any beat on either side before the run is given up.
    localparam int QUIET_LIMIT    = 4000;
    // Settling time after the last expected result; the block is two stages deep.
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        frame_start;

    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  seq_number;
    logic [7:0]  channel;
    logic [31:0] bitrate;
    logic [1:0]  entry_index;
    logic [31:0] can_id;
    logic [7:0]  data_length;
    logic [7:0]  frame_flags;
    logic [63:0] payload;

    // Byte image of the frame that is being sent next. It is longer than a
    // frame so that bytes past the end, and the saturating position, get sent.
    logic [7:0]  frame_image [0:299];

    frame_decode_scoreboard frame_sb;

    // Handshakes between the stimulus process and the result sink.
    bit          hold_request = 1'b0;
    bit          calm         = 1'b0;

    always #5 clk = ~clk;

    sync_frame_decoder_unit #(
        .FRAME_BYTES (FRAME_LEN),
        .MAX_ENTRIES (ENTRY_SLOTS),
        .CHANNELS    (CHANNEL_COUNT),
        .MAX_SHIFT   (SHIFT_LIMIT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .seq_number  (seq_number),
        .channel     (channel),
        .bitrate     (bitrate),
        .entry_index (entry_index),
        .can_id      (can_id),
        .data_length (data_length),
        .frame_flags (frame_flags),
        .payload     (payload)
    );

    // ------------------------------------------------------------------
    // Frame image construction.
    // ------------------------------------------------------------------

    // Fills the whole image with random bytes, or with zeros.
    task automatic clear_frame(input bit noise);
        for (int i = 0; i < 300; i++) frame_image[i] = noise ? 8'($urandom_range(0, 255)) : 8'h00;
    endtask

    // Writes the magic word at byte shift s, followed by the header fields.
    task automatic put_header(input int s, input logic [7:0] ver, input logic [7:0] seq,
                              input logic [7:0] cnt, input logic [7:0] mask);
        for (int k = 0; k < 4; k++) frame_image[s + k] = MAGIC[k];
        frame_image[s + 4]         = ver;
        frame_image[s + OFS_SEQ]   = seq;
        frame_image[s + OFS_COUNT] = cnt;
        frame_image[s + OFS_MASK]  = mask;
    endtask

    task automatic put_rate(input int s, input int ch, input logic [31:0] word);
        for (int k = 0; k < 4; k++) frame_image[s + OFS_RATE + 4 * ch + k] = word[8 * k +: 8];
    endtask

    task automatic put_entry(input int s, input int i, input logic [31:0] id,
                             input logic [7:0] len, input logic [7:0] flags,
                             input logic [7:0] ch, input logic [63:0] data);
        int base;
        base = s + OFS_ENTRY + ENTRY_BYTES * i;
        for (int k = 0; k < 4; k++) frame_image[base + k] = id[8 * k +: 8];
        frame_image[base + 4] = len;
        frame_image[base + 5] = flags;
        frame_image[base + 6] = ch;
        for (int k = 0; k < 8; k++) frame_image[base + 8 + k] = data[8 * k +: 8];
    endtask

    // A quarter of the bitrate words are zero, which must give no result.
    function automatic logic [31:0] random_rate();
        return ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
    endfunction

    // Header with random content at shift s, both bitrate words and four entries.
    // Most entries are well formed; some carry a bad length or a bad channel.
    task automatic build_good_frame(input int s, input logic [7:0] ver);
        logic [7:0] cnt;
        logic [7:0] mask;
        logic [7:0] len;
        logic [7:0] ch;
        cnt  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, ENTRY_SLOTS));
        mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
        put_header(s, ver, 8'($urandom_range(0, 255)), cnt, mask);
        put_rate(s, 0, random_rate());
        put_rate(s, 1, random_rate());
        for (int i = 0; i < ENTRY_SLOTS; i++) begin
            len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 8));
            ch  = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, CHANNEL_COUNT - 1));
            put_entry(s, i, $urandom(), len, 8'($urandom_range(0, 255)), ch,
                      {$urandom(), $urandom()});
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. Inputs change only at the falling edge; a beat is taken
    // at the rising edge where in_valid is high and in_stall is low.
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic st, input bit gaps);
        if (gaps && $urandom_range(0, 9) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid    = 1'b1;
        rx_byte     = b;
        frame_start = st;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frame_sb.note_byte(b, st);
        @(negedge clk);
    endtask

    task automatic send_frame(input int len, input bit start_mark, input bit gaps);
        for (int i = 0; i < len; i++) send_byte(frame_image[i], start_mark && i == 0, gaps);
    endtask

    // Builds and sends one random transfer. Most are well-formed frames with
    // random content; the rest carry a bad version, a corrupted magic word,
    // plain noise or all zeros. Lengths are mostly cut short, since the
    // entries end well before the frame does, with some full frames that run
    // a little past the end and a rare one that runs past the saturation point.
    task automatic send_random_frame(output int counted);
        int         pick;
        int         len_pick;
        int         len;
        int         s;
        logic [7:0] ver;
        bit         gaps;
        pick = $urandom_range(0, 19);
        s    = $urandom_range(0, SHIFT_LIMIT);
        clear_frame(pick != 18);
        if (pick < 16 || pick == 19) begin
            ver = VERSION_OK;
            if (pick >= 14 && pick < 16) begin
                ver = 8'($urandom_range(0, 255));
                if (ver == VERSION_OK) ver = 8'h00;
            end
            build_good_frame(s, ver);
            if (pick == 19) begin
                frame_image[s + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        len_pick = $urandom_range(0, 19);
        if (len_pick < 5) begin
            len = FRAME_LEN + $urandom_range(0, 8);
        end else if (len_pick == 5) begin
            len = $urandom_range(256, 270);
        end else begin
            len = $urandom_range(6, 100);
        end
        gaps = !calm && $urandom_range(0, 3) != 0;
        send_frame(len, 1'b1, gaps);
        counted = (len < FRAME_LEN) ? len : FRAME_LEN;
    endtask

    // ------------------------------------------------------------------
    // Result side. The sink stalls in random bursts, sometimes runs free
    // for a stretch, and on request holds off for a long time so that the
    // block backs up into its input.
    // ------------------------------------------------------------------

    initial begin : result_sink
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall    = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                n         = $urandom_range(1, 18);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end else if (!calm && $urandom_range(0, 39) == 0) begin
                n = $urandom_range(20, 80);
                repeat (n) @(negedge clk);
            end
        end
    end

    // Every result beat is checked against the oldest expectation. The same
    // process keeps the watchdog: it gives up once its quiet count reaches
    // QUIET_LIMIT; any beat taken on either side clears the count.
    initial begin : result_monitor
        int             quiet;
        decode_result_t got;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                got = {kind, seq_number, channel, bitrate, entry_index, can_id,
                       data_length, frame_flags, payload};
                frame_sb.check_result(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("sync_frame_decoder_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial begin : stimulus
        int counted;
        int random_items;
        frame_sb    = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        frame_start = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Bytes right after reset with no start mark still form a frame from
        // byte 0. Sequence number at its top value.
        clear_frame(1'b0);
        put_header(0, VERSION_OK, 8'hFF, 8'h00, 8'h00);
        send_frame(8, 1'b0, 1'b1);

        // An all-zero frame finds no magic and is dropped silently.
        clear_frame(1'b0);
        send_frame(8, 1'b1, 1'b1);

        // Magic at shift 0 with a bad version drops the frame.
        clear_frame(1'b1);
        put_header(0, 8'hFF, 8'h11, 8'h00, 8'h00);
        send_frame(10, 1'b1, 1'b1);

        // Magic at the largest shift, sequence number zero, transfer cut short.
        clear_frame(1'b1);
        put_header(SHIFT_LIMIT, VERSION_OK, 8'h00, 8'h00, 8'h00);
        send_frame(12, 1'b1, 1'b1);

        // Shift 1 with version zero.
        clear_frame(1'b1);
        put_header(1, 8'h00, 8'h22, 8'h00, 8'h00);
        send_frame(8, 1'b1, 1'b1);

        // A full frame at shift 2 that runs past the end. The entry count is
        // capped, the mask enables every channel but the second bitrate word
        // is zero. The entries give a transmit with all bits set, a bad length
        // that also has a bad channel (length wins), a bad channel and the
        // largest length code.
        clear_frame(1'b1);
        put_header(2, VERSION_OK, 8'hA5, 8'hFF, 8'hFF);
        put_rate(2, 0, 32'hFFFF_FFFF);
        put_rate(2, 1, 32'h0);
        put_entry(2, 0, 32'hFFFF_FFFF, 8'd8, 8'hFF, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        put_entry(2, 1, 32'h0000_0001, 8'd9, 8'h00, 8'hFF, 64'h0);
        put_entry(2, 2, 32'h0000_0000, 8'd0, 8'h5A, 8'd2, 64'h0123_4567_89AB_CDEF);
        put_entry(2, 3, 32'h8000_0000, 8'hFF, 8'h01, 8'd0, 64'h8000_0000_0000_0001);
        send_frame(FRAME_LEN + 8, 1'b1, 1'b1);

        // One entry of all zeros. Only the second channel is enabled, so the
        // nonzero first word gives nothing and the second one is reported.
        clear_frame(1'b0);
        put_header(0, VERSION_OK, 8'h01, 8'd1, 8'h02);
        put_rate(0, 0, 32'h0000_0001);
        put_rate(0, 1, 32'h8000_0000);
        put_entry(0, 0, 32'h0, 8'd0, 8'h00, 8'd0, 64'h0);
        send_frame(OFS_ENTRY + ENTRY_BYTES, 1'b1, 1'b1);

        // A long transfer with no entries and a zero first word; the byte
        // position saturates and everything past the frame is ignored.
        clear_frame(1'b1);
        put_header(1, VERSION_OK, 8'h7E, 8'd0, 8'h01);
        put_rate(1, 0, 32'h0);
        send_frame(262, 1'b1, 1'b1);

        // Back pressure: the sink holds off for a long stretch while a full
        // frame with many results is sent without gaps, so in_stall must rise.
        clear_frame(1'b1);
        build_good_frame(0, VERSION_OK);
        frame_image[OFS_COUNT] = 8'(ENTRY_SLOTS);
        frame_image[OFS_MASK]  = 8'h03;
        put_rate(0, 0, 32'h1234_5678);
        put_rate(0, 1, 32'h9ABC_DEF0);
        hold_request = 1'b1;
        send_frame(FRAME_LEN, 1'b1, 1'b0);

        // Random part. Ignored bytes past the frame end are not counted.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            send_random_frame(counted);
            random_items += counted;
        end

        // Closing stretch with neither side idling.
        calm = 1'b1;
        repeat (2) begin
            send_random_frame(counted);
        end
        in_valid = 1'b0;

        // Let the last results drain, then give the block a few more cycles to
        // show any beat that should not be there.
        while (frame_sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frame_sb.errors == 0 && frame_sb.pending() == 0) begin
            $display("sync_frame_decoder_unit test passed");
        end else begin
            $display("sync_frame_decoder_unit test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_magic_search.sv
hw/rtl/sync_frame_decoder_unit.sv
dv/sfd_tb_pkg.sv
dv/tb_sync_frame_decoder_unit.sv
